FILE: hdl/adlt_pkg.sv
package adlt_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [23:0] length;
    logic [13:0] dac_rate;
    logic [1:0]  tv_system;
    logic [25:0] vi_time;
  } in_word_t;

  typedef struct packed {
    logic [17:0] read_value;
    logic        busy_res;
    logic        full_res;
    logic        irq;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_LEN_WRITE   = 3'd1,
    OP_LEN_READ    = 3'd2,
    OP_STATUS_READ = 3'd3,
    OP_SET_FREQ    = 3'd4,
    OP_SET_VI_TIME = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    TV_NTSC = 2'd0,
    TV_PAL  = 2'd1,
    TV_MPAL = 2'd2
  } tv_e;

  localparam int unsigned DendW = 34;
  localparam int unsigned SorW  = 28;
  localparam int unsigned StepW = 6;

  localparam logic [StepW-1:0] DivLastStep = 6'd33;

  localparam logic [23:0] LenLimit   = 24'h040000;
  localparam logic [25:0] FreqPal    = 26'd49656530;
  localparam logic [25:0] FreqMpal   = 26'd48628316;
  localparam logic [25:0] FreqNtsc   = 26'd48681812;
  localparam logic [15:0] DefaultCpb = 16'd500;
  localparam logic [5:0]  FpsPal     = 6'd50;
  localparam logic [5:0]  FpsOther   = 6'd60;
  localparam logic [17:0] ReadSat    = 18'h3FFF8;
  localparam logic [15:0] CpbMax     = 16'hFFFF;

  typedef struct packed {
    logic             start;
    logic [DendW-1:0] dividend;
    logic [SorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DendW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hdl/audio_dma_length_timer.sv
// Words that need no division pass through the exec and result states; set frequency,
// length reads while a countdown runs and set vi time with a derived rate also pass
// through the div state, which runs 34 steps on the shared one-bit-per-cycle divider.
// Throughput: one word at a time; the input stalls until the result is stored.
// Reset (rst_ni low, asynchronous) clears the timer, the queue and the flags,
// sets counts per byte to 500 and frames per second to 60.
module audio_dma_length_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  adlt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output adlt_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_RESULT = 4'b1000
  } st_e;

  st_e                 state_q, state_d;
  adlt_pkg::in_word_t  item_q;
  logic [15:0]         user_cpb_q;
  logic [33:0]         countdown_q, countdown_d;
  logic [17:0]         queued_q, queued_d;
  logic                busy_q, busy_d;
  logic                full_q, full_d;
  logic [15:0]         derived_cpb_q, derived_cpb_d;
  logic [27:0]         bps_q, bps_d;
  logic [5:0]          fps_q, fps_d;
  logic [17:0]         rv_q, rv_d;
  logic                irq_q, irq_d;
  logic                out_valid_q, out_valid_d;
  adlt_pkg::out_word_t out_q, out_d;

  adlt_pkg::div_req_t  div_req;
  adlt_pkg::div_rsp_t  div_rsp;

  logic [15:0]         cpb_sel;
  logic [15:0]         cpb;
  logic [17:0]         mul_a;
  logic [33:0]         prod;
  logic [33:0]         cd_dec;
  logic [25:0]         freq_c;
  logic [31:0]         vi_cps;
  logic [33:0]         quo;
  adlt_pkg::op_e       op;

  assign op      = adlt_pkg::op_e'(item_q.op);
  assign cpb_sel = (user_cpb_q != 16'd0) ? user_cpb_q : derived_cpb_q;
  assign cpb     = (cpb_sel != 16'd0) ? cpb_sel : 16'd1;
  assign mul_a   = (op == adlt_pkg::OP_TICK) ? queued_q : item_q.length[17:0];
  assign prod    = 34'(mul_a) * 34'(cpb);
  assign cd_dec  = countdown_q - 34'd1;
  assign vi_cps  = 32'(item_q.vi_time) * 32'(fps_q);
  assign quo     = div_rsp.quotient;

  always_comb begin
    case (adlt_pkg::tv_e'(item_q.tv_system))
      adlt_pkg::TV_PAL:  freq_c = adlt_pkg::FreqPal;
      adlt_pkg::TV_MPAL: freq_c = adlt_pkg::FreqMpal;
      default:           freq_c = adlt_pkg::FreqNtsc;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    countdown_d   = countdown_q;
    queued_d      = queued_q;
    busy_d        = busy_q;
    full_d        = full_q;
    derived_cpb_d = derived_cpb_q;
    bps_d         = bps_q;
    fps_d         = fps_q;
    rv_d          = rv_q;
    irq_d         = irq_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    div_req       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rv_d    = '0;
        irq_d   = 1'b0;
        state_d = ST_RESULT;
        case (op)
          adlt_pkg::OP_TICK: begin
            if (countdown_q != 34'd0) begin
              countdown_d = cd_dec;
              if (cd_dec == 34'd0) begin
                irq_d  = 1'b1;
                full_d = 1'b0;
                if (queued_q != 18'd0) begin
                  countdown_d = prod;
                  queued_d    = '0;
                end else begin
                  busy_d = 1'b0;
                end
              end
            end
          end
          adlt_pkg::OP_LEN_WRITE: begin
            if (item_q.length == 24'd0) begin
              countdown_d = '0;
              queued_d    = '0;
              busy_d      = 1'b0;
              full_d      = 1'b0;
            end else if (item_q.length < adlt_pkg::LenLimit) begin
              busy_d = 1'b1;
              if (queued_q == 18'd0) begin
                if (countdown_q == 34'd0) begin
                  countdown_d = prod;
                end else begin
                  queued_d = item_q.length[17:0];
                  full_d   = 1'b1;
                end
              end
            end
          end
          adlt_pkg::OP_LEN_READ: begin
            if (countdown_q != 34'd0) begin
              div_req.start    = 1'b1;
              div_req.dividend = countdown_q;
              div_req.divisor  = 28'(cpb);
              state_d          = ST_DIV;
            end
          end
          adlt_pkg::OP_SET_FREQ: begin
            div_req.start    = 1'b1;
            div_req.dividend = 34'(freq_c);
            div_req.divisor  = 28'(item_q.dac_rate) + 28'd1;
            state_d          = ST_DIV;
          end
          adlt_pkg::OP_SET_VI_TIME: begin
            if (bps_q != 28'd0 && user_cpb_q == 16'd0) begin
              div_req.start    = 1'b1;
              div_req.dividend = 34'(vi_cps);
              div_req.divisor  = bps_q;
              state_d          = ST_DIV;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_RESULT;
          case (op)
            adlt_pkg::OP_LEN_READ: begin
              if (quo[33:18] != 16'd0) begin
                rv_d = adlt_pkg::ReadSat;
              end else begin
                rv_d = {quo[17:3], 3'b000};
              end
            end
            adlt_pkg::OP_SET_FREQ: begin
              bps_d = {quo[25:0], 2'b00};
              fps_d = (adlt_pkg::tv_e'(item_q.tv_system) == adlt_pkg::TV_PAL) ?
                      adlt_pkg::FpsPal : adlt_pkg::FpsOther;
            end
            default: begin
              if (quo[33:16] != 18'd0) begin
                derived_cpb_d = adlt_pkg::CpbMax;
              end else if (quo[15:0] == 16'd0) begin
                derived_cpb_d = 16'd1;
              end else begin
                derived_cpb_d = quo[15:0];
              end
            end
          endcase
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.read_value = rv_q;
          out_d.busy_res   = busy_q;
          out_d.full_res   = full_q;
          out_d.irq        = irq_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      user_cpb_q    <= '0;
      countdown_q   <= '0;
      queued_q      <= '0;
      busy_q        <= 1'b0;
      full_q        <= 1'b0;
      derived_cpb_q <= adlt_pkg::DefaultCpb;
      bps_q         <= '0;
      fps_q         <= adlt_pkg::FpsOther;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      countdown_q   <= countdown_d;
      queued_q      <= queued_d;
      busy_q        <= busy_d;
      full_q        <= full_d;
      derived_cpb_q <= derived_cpb_d;
      bps_q         <= bps_d;
      fps_q         <= fps_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        user_cpb_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_word_i;
    end
    rv_q  <= rv_d;
    irq_q <= irq_d;
    out_q <= out_d;
  end

  adlt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hdl/adlt_div.sv
module adlt_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adlt_pkg::div_req_t  req_i,
  output adlt_pkg::div_rsp_t  rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [adlt_pkg::StepW-1:0]     cnt_q, cnt_d;
  logic [adlt_pkg::SorW-1:0]      rem_q, rem_d;
  logic [adlt_pkg::DendW-1:0]     quo_q, quo_d;
  logic [adlt_pkg::SorW-1:0]      div_q, div_d;
  logic [adlt_pkg::SorW:0]        trial;
  logic [adlt_pkg::SorW:0]        diff;
  logic                           fits;

  // One restoring step per cycle; the dividend shifts out of the top of
  // the quotient register while quotient bits shift in at the bottom.
  assign trial = {rem_q, quo_q[adlt_pkg::DendW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[adlt_pkg::SorW-1:0] : trial[adlt_pkg::SorW-1:0];
      quo_d = {quo_q[adlt_pkg::DendW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == adlt_pkg::DivLastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: hdl/adlt_chk.sv
module adlt_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input adlt_pkg::out_word_t out_word_o
);

  // The second buffer slot can only be occupied while a transfer runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_word_o.full_res || out_word_o.busy_res))
    else $error("full reported without busy");

  // An expiry word comes from a tick, which never carries a read value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.irq) |-> (out_word_o.read_value == 18'd0))
    else $error("interrupt word carries a read value");

  // The remaining length is reported in bytes, rounded down to a multiple of eight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.read_value[2:0] == 3'd0))
    else $error("read value has low bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_word_o))
    else $error("stalled output word changed");

endmodule

bind audio_dma_length_timer adlt_chk u_adlt_chk (.*);
